// ===== src/cdjd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdjd_pkg
// Constants and helpers shared by the Julian Day to calendar date pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdjd_pkg;

	// width of the whole day number and of the internal day counts
	localparam int unsigned DAY_W  = 23;
	localparam int unsigned B_W    = 24;
	localparam int unsigned C_W    = 15;
	localparam int unsigned X_W    = 10;
	localparam int unsigned E_W    = 5;

	// first day number of the Gregorian calendar
	localparam logic [DAY_W-1:0] GREGORIAN_START = 23'd2299161;

	// 4 * 1867216.25, offset of the Gregorian century correction
	localparam logic [DAY_W+1:0] ALPHA_OFFSET = 25'd7468865;
	localparam logic [B_W-1:0]   B_OFFSET     = 24'd1524;
	// 20 * 122.1
	localparam logic [28:0]      C_OFFSET     = 29'd2442;
	localparam logic [10:0]      DAYS_4Y      = 11'd1461;
	localparam logic [15:0]      YEAR_BASE    = 16'd4716;
	localparam logic [15:0]      YEAR_BASE_JF = 16'd4715;

	// reciprocals: floor(n / d) == (n * ceil(2^k / d)) >> k when n < 2^(k - log2 d)
	localparam int unsigned K_ALPHA = 43;
	localparam logic [25:0] M_ALPHA =
		26'(((64'd1 << K_ALPHA) + 64'd146097 - 64'd1) / 64'd146097);

	localparam int unsigned K_WDAY = 27;
	localparam logic [24:0] M_WDAY =
		25'(((64'd1 << K_WDAY) + 64'd7 - 64'd1) / 64'd7);

	localparam int unsigned K_C = 42;
	localparam logic [29:0] M_C =
		30'(((64'd1 << K_C) + 64'd7305 - 64'd1) / 64'd7305);

	// e = floor(10000 x / 306001), the factor 10000 folded into the reciprocal
	localparam int unsigned K_E = 43;
	localparam logic [38:0] M_E =
		39'(64'd10000 * (((64'd1 << K_E) + 64'd306001 - 64'd1) / 64'd306001));

	// floor(30.6001 * e) for the month index
	function automatic logic [8:0] month_days(input logic [E_W-1:0] e);
		logic [8:0] r;
		case (e)
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd153;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd306;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			5'd13:   r = 9'd397;
			5'd14:   r = 9'd428;
			5'd15:   r = 9'd459;
			5'd16:   r = 9'd489;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/calendar_date_from_julian_day_top.sv =====
// ----------------------------------------------------------------------------
// calendar_date_from_julian_day_top
// Julian Day (whole part and fraction of JD + 0.5) to calendar date and
// weekday, Julian calendar before day 2299161 and Gregorian from there on.
// ----------------------------------------------------------------------------
// A date enters on any cycle with start high; busy is always low, so one
// transaction can be started every clock cycle. Each result appears with done
// high for exactly one cycle, in start order, after six register stages that
// split the chain of constant multiplies and table look-ups of the conversion.
// The receiver cannot stall the pipeline, so done must be sampled on the cycle
// it is high.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_from_julian_day_top
	import cdjd_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [DAY_W-1:0]         day_number,
	input  wire logic [FRACTION_BITS-1:0] day_fraction,
	output logic                          done,
	output logic signed [15:0]            year,
	output logic [3:0]                    month,
	output logic [4:0]                    day_of_month,
	output logic [FRACTION_BITS-1:0]      fraction_out,
	output logic [2:0]                    weekday
);

	logic                     v_s1, v_s2, v_s3;
	logic [DAY_W-1:0]         z_s1;
	logic                     greg_s1;
	logic [50:0]              aprod_s1;
	logic [48:0]              wprod_s1;
	logic [2:0]               zp1_lo_s1;
	logic [B_W-1:0]           b_s2, b_s3;
	logic [2:0]               wd_s2, wd_s3;
	logic [58:0]              cprod_s3;
	logic [FRACTION_BITS-1:0] f_s1, f_s2, f_s3;

	logic [B_W-1:0]   zp1;
	logic [DAY_W+1:0] n_alpha;
	logic [7:0]       alpha;
	logic [B_W-1:0]   a_greg;
	logic [B_W-1:0]   a_n;
	logic [28:0]      n_c;

	// never stalls
	assign busy = 1'b0;

	// stage 1: century correction and weekday reciprocals
	assign zp1     = B_W'(day_number) + 24'd1;
	assign n_alpha = {day_number, 2'b00} - ALPHA_OFFSET;

	// stage 2: Gregorian shift back onto the Julian day count
	assign alpha  = aprod_s1[K_ALPHA+7:K_ALPHA];
	assign a_greg = B_W'(z_s1) + 24'd1 + B_W'(alpha) - B_W'(alpha >> 2);
	assign a_n    = greg_s1 ? a_greg : B_W'(z_s1);

	// stage 3: numerator of the year estimate
	assign n_c = 29'(b_s2) * 29'd20 - C_OFFSET;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		z_s1      <= day_number;
		greg_s1   <= (day_number >= GREGORIAN_START);
		aprod_s1  <= 51'(n_alpha) * 51'(M_ALPHA);
		wprod_s1  <= 49'(zp1) * 49'(M_WDAY);
		zp1_lo_s1 <= zp1[2:0];
		f_s1      <= day_fraction;

		b_s2  <= a_n + B_OFFSET;
		// (z + 1) - 7q modulo 8 is the low bits of (z + 1) + q
		wd_s2 <= zp1_lo_s1 + wprod_s1[K_WDAY+2:K_WDAY];
		f_s2  <= f_s1;

		b_s3     <= b_s2;
		cprod_s3 <= 59'(n_c) * 59'(M_C);
		wd_s3    <= wd_s2;
		f_s3     <= f_s2;
	end

	// year, month and day split
	cdjd_ymd #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_ymd (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (v_s3),
		.b_in         (b_s3),
		.cprod_in     (cprod_s3),
		.weekday_in   (wd_s3),
		.fraction_in  (f_s3),
		.done         (done),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.fraction_out (fraction_out),
		.weekday      (weekday)
	);

endmodule

`default_nettype wire

// ===== src/cdjd_ymd.sv =====
// ----------------------------------------------------------------------------
// cdjd_ymd
// Back half of the pipeline: splits the shifted day count into year, month
// and day of month, and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdjd_ymd
	import cdjd_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [B_W-1:0]           b_in,
	input  wire logic [58:0]              cprod_in,
	input  wire logic [2:0]               weekday_in,
	input  wire logic [FRACTION_BITS-1:0] fraction_in,
	output logic                          done,
	output logic signed [15:0]            year,
	output logic [3:0]                    month,
	output logic [4:0]                    day_of_month,
	output logic [FRACTION_BITS-1:0]      fraction_out,
	output logic [2:0]                    weekday
);

	logic                     v_s4, v_s5, v_s6;
	logic [C_W-1:0]           c_s4, c_s5;
	logic [X_W-1:0]           x_s4, x_s5;
	logic [48:0]              eprod_s5;
	logic [2:0]               wd_s4, wd_s5;
	logic [FRACTION_BITS-1:0] f_s4, f_s5;

	logic [C_W-1:0] c_n;
	logic [25:0]    dprod;
	logic [B_W-1:0] b_minus_d;
	logic [E_W-1:0] e_n;
	logic [3:0]     month_n;
	logic [8:0]     dom_n;

	// stage 4: years since the epoch and the day within that year
	assign c_n       = cprod_in[K_C+C_W-1:K_C];
	assign dprod     = 26'(c_n) * 26'(DAYS_4Y);
	assign b_minus_d = b_in - dprod[25:2];

	// stage 6: month index, day of month and year
	assign e_n     = eprod_s5[K_E+E_W-1:K_E];
	assign month_n = (e_n < 5'd14) ? 4'(e_n - 5'd1) : 4'(e_n - 5'd13);
	assign dom_n   = 9'(x_s5) - month_days(e_n);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		c_s4  <= c_n;
		x_s4  <= b_minus_d[X_W-1:0];
		wd_s4 <= weekday_in;
		f_s4  <= fraction_in;

		c_s5     <= c_s4;
		x_s5     <= x_s4;
		eprod_s5 <= 49'(x_s4) * 49'(M_E);
		wd_s5    <= wd_s4;
		f_s5     <= f_s4;

		month        <= month_n;
		day_of_month <= dom_n[4:0];
		if (month_n > 4'd2) begin
			year <= $signed(16'(c_s5) - YEAR_BASE);
		end else begin
			year <= $signed(16'(c_s5) - YEAR_BASE_JF);
		end
		fraction_out <= f_s5;
		weekday      <= wd_s5;
	end

	assign done = v_s6;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Julian Day to calendar date pipeline. A queue
// of day numbers and fractions feeds a clocked driver with random gaps. Each
// accepted transaction is converted here by an independent integer version
// of the Meeus method, and a monitor compares every done strobe with the
// oldest pending date, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb
	import cdjd_pkg::*;
();

	localparam int          FRAC_W         = 16;
	localparam int unsigned LAST_DAY       = 8388607;
	localparam int unsigned FIRST_GREG_DAY = 2299161;
	localparam int unsigned RANDOM_ITEMS   = 1350;
	localparam int unsigned DRAIN_EVERY    = 450;
	localparam int unsigned SETTLE_CYCLES  = 20;
	localparam int unsigned CYCLE_LIMIT    = 500000;

	typedef struct {
		logic [DAY_W-1:0]  day;
		logic [FRAC_W-1:0] frac;
		int unsigned       gap;
		bit                drain;
	} jd_item_t;

	typedef struct {
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         dom;
		logic [FRAC_W-1:0]  frac;
		logic [2:0]         wday;
		longint             stamp;
	} calendar_date_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     start        = 1'b0;
	logic [DAY_W-1:0]         day_number   = '0;
	logic [FRAC_W-1:0]        day_fraction = '0;
	logic                     busy;
	logic                     done;
	logic signed [15:0]       year;
	logic [3:0]               month;
	logic [4:0]               day_of_month;
	logic [FRAC_W-1:0]        fraction_out;
	logic [2:0]               weekday;

	jd_item_t       pending_days[$];
	calendar_date_t expected_dates[$];
	int unsigned    gap_left     = 0;
	int unsigned    accepted_cnt = 0;
	int unsigned    total_items  = 0;
	int unsigned    fail_cnt     = 0;
	int unsigned    cycle_cnt    = 0;

	calendar_date_from_julian_day_top #(
		.FRACTION_BITS(FRAC_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.day_number   (day_number),
		.day_fraction (day_fraction),
		.done         (done),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.fraction_out (fraction_out),
		.weekday      (weekday)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// integer form of the Meeus conversion, Julian before the switch day
	function automatic calendar_date_t jd_to_date(input logic [DAY_W-1:0] jd,
			input logic [FRAC_W-1:0] frac);
		longint unsigned z, a, alpha, b, c, d, e, dom, mon;
		longint          yr;
		calendar_date_t  r;
		z = jd;
		if (z < FIRST_GREG_DAY) begin
			a = z;
		end else begin
			alpha = (4 * z - 64'd7468865) / 64'd146097;
			a = z + 1 + alpha - alpha / 4;
		end
		b = a + 1524;
		c = (20 * b - 64'd2442) / 64'd7305;
		d = (1461 * c) / 4;
		e = (10000 * (b - d)) / 64'd306001;
		dom = b - d - (64'd306001 * e) / 10000;
		mon = (e < 14) ? e - 1 : e - 13;
		if (mon > 2)
			yr = $signed(c) - 4716;
		else
			yr = $signed(c) - 4715;
		r.year  = yr[15:0];
		r.month = mon[3:0];
		r.dom   = dom[4:0];
		r.frac  = frac;
		r.wday  = 3'((z + 1) % 7);
		r.stamp = 0;
		return r;
	endfunction

	// gap after a transaction: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		else if (roll < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [FRAC_W-1:0] pick_fraction();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		else
			return FRAC_W'($urandom_range(0, 65535));
	endfunction

	// day numbers clustered where the conversion has its edges
	function automatic logic [DAY_W-1:0] pick_day();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return DAY_W'($urandom_range(0, LAST_DAY));
		else if (roll < 75)
			return DAY_W'($urandom_range(FIRST_GREG_DAY - 1500, FIRST_GREG_DAY + 1500));
		else if (roll < 85)
			return DAY_W'($urandom_range(0, 3000));
		else if (roll < 95)
			return DAY_W'($urandom_range(LAST_DAY - 5000, LAST_DAY));
		else
			return DAY_W'($urandom_range(2415000, 2470000));
	endfunction

	// driver: records each accepted transaction, then presents the next one
	always @(posedge clk) begin
		jd_item_t       nxt;
		calendar_date_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want = jd_to_date(day_number, day_fraction);
				want.stamp = $time;
				expected_dates.push_back(want);
				accepted_cnt++;
			end
			if (start && busy) begin
				// hold the transaction until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_days.size() > 0 &&
					!(pending_days[0].drain && expected_dates.size() != 0)) begin
				nxt = pending_days.pop_front();
				start        <= 1'b1;
				day_number   <= nxt.day;
				day_fraction <= nxt.frac;
				gap_left     = nxt.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: each done strobe against the oldest date accepted earlier
	always @(posedge clk) begin
		calendar_date_t want;
		if (arst_n && done) begin
			if (expected_dates.size() == 0 || expected_dates[0].stamp >= $time) begin
				$error("unexpected result: year %0d month %0d day %0d", year, month,
					day_of_month);
				fail_cnt++;
			end else begin
				want = expected_dates.pop_front();
				if (year !== want.year) begin
					$error("year mismatch: expected %0d, got %0d", want.year, year);
					fail_cnt++;
				end
				if (month !== want.month) begin
					$error("month mismatch: expected %0d, got %0d", want.month, month);
					fail_cnt++;
				end
				if (day_of_month !== want.dom) begin
					$error("day_of_month mismatch: expected %0d, got %0d", want.dom,
						day_of_month);
					fail_cnt++;
				end
				if (fraction_out !== want.frac) begin
					$error("fraction_out mismatch: expected %0h, got %0h", want.frac,
						fraction_out);
					fail_cnt++;
				end
				if (weekday !== want.wday) begin
					$error("weekday mismatch: expected %0d, got %0d", want.wday, weekday);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned directed_days[$];
		jd_item_t    it;
		int unsigned burst_left;
		burst_left = 0;

		// calendar switch and a full week around it, start of the range,
		// leap days, century years, top of the range and bit patterns
		directed_days = '{2299158, 2299159, 2299160, 2299161, 2299162, 2299163,
			2299164, 0, 1, 59, 60, 2451544, 2451545, 2451604, 2451605, 2415079,
			2415080, LAST_DAY - 1, LAST_DAY, 23'h555555, 23'h2AAAAA};
		foreach (directed_days[i]) begin
			it.day   = DAY_W'(directed_days[i]);
			case (i % 4)
				0:       it.frac = '0;
				1:       it.frac = '1;
				2:       it.frac = 16'h5555;
				default: it.frac = 16'hAAAA;
			endcase
			it.gap   = pick_gap();
			it.drain = (directed_days[i] == FIRST_GREG_DAY);
			pending_days.push_back(it);
		end

		// random part, with stretches of back-to-back transactions
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			it.day  = pick_day();
			it.frac = pick_fraction();
			if (burst_left == 0 && $urandom_range(0, 19) == 0)
				burst_left = $urandom_range(20, 60);
			if (burst_left > 0) begin
				it.gap = 0;
				burst_left--;
			end else begin
				it.gap = pick_gap();
			end
			it.drain = (n % DRAIN_EVERY == 0);
			pending_days.push_back(it);
		end
		total_items = pending_days.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < total_items) @(negedge clk);
		while (expected_dates.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_cnt == 0 && expected_dates.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
